[hdl/ppr_pkg.sv]
// Shared types, codes and helpers of the Paxos proposer round block.
// No dependencies; every other file in hdl uses it by scoped names.

package ppr_pkg;

	// Defaults and fixed widths
	localparam int MAX_ACCEPTORS_DEF = 15;
	localparam int CNT_W             = 4;
	localparam int ID_W              = 4;
	localparam int NUM_W             = 32;
	localparam int ACC_COUNT_RESET   = 5;

	// Register indexes
	localparam int REG_ACCEPTOR_COUNT = 0;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_PREP = 2'd1,
		PH_ACC  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		A_START = 2'd0,
		A_PREP  = 2'd1,
		A_ACC   = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		K_NONE       = 3'd0,
		K_ACCEPT_REQ = 3'd1,
		K_CHOSEN     = 3'd2,
		K_FAILED     = 3'd3,
		K_RESEND     = 3'd4
	} kind_t;

	typedef struct packed {
		logic [1:0]              action;
		logic [ID_W-1:0]         acceptor_id;
		logic                    busy_req;
		logic signed [NUM_W-1:0] proposal_number;
		logic signed [NUM_W-1:0] reply_value;
	} item_t;

	typedef struct packed {
		kind_t                   kind;
		logic [ID_W-1:0]         target_id;
		logic signed [NUM_W-1:0] round_number;
		logic signed [NUM_W-1:0] round_value;
	} result_t;

	// Saturating increment of a reply counter
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		r = (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
		return r;
	endfunction

endpackage

[hdl/ppr_if.sv]
// Valid/ready channels for items into and results out of the proposer round.
// Depends on ppr_pkg for field widths.

interface ppr_item_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       action;
	logic [ppr_pkg::ID_W-1:0]         acceptor_id;
	logic                             busy_req;
	logic signed [ppr_pkg::NUM_W-1:0] proposal_number;
	logic signed [ppr_pkg::NUM_W-1:0] reply_value;

	modport source (output valid, action, acceptor_id, busy_req, proposal_number,
		reply_value, input ready);
	modport sink (input valid, action, acceptor_id, busy_req, proposal_number,
		reply_value, output ready);
endinterface

interface ppr_result_if;
	logic                             valid;
	logic                             ready;
	logic [2:0]                       kind;
	logic [ppr_pkg::ID_W-1:0]         target_id;
	logic signed [ppr_pkg::NUM_W-1:0] round_number;
	logic signed [ppr_pkg::NUM_W-1:0] round_value;

	modport source (output valid, kind, target_id, round_number, round_value,
		input ready);
	modport sink (input valid, kind, target_id, round_number, round_value,
		output ready);
endinterface

[hdl/ppr_round.sv]
// Round state of the proposer: phase, numbers, counters and the decision
// logic for one item. Depends on ppr_pkg.

module ppr_round #(
	parameter int MAX_ACCEPTORS = ppr_pkg::MAX_ACCEPTORS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ppr_pkg::CNT_W-1:0]     acceptor_count,
	input  logic                          fire,
	input  ppr_pkg::item_t                item,
	output ppr_pkg::result_t              res
);

	localparam logic [ppr_pkg::CNT_W-1:0] MAX_CNT =
		ppr_pkg::CNT_W'((MAX_ACCEPTORS > 15) ? 15 : MAX_ACCEPTORS);

	typedef struct packed {
		logic is_start;
		logic busy_reply;
		logic prep_done;
		logic acc_done;
		logic adopt;
		logic reach_p;
		logic fail_p;
		logic too_high;
		logic chosen;
		logic fail_a;
	} flags_t;

	ppr_pkg::phase_t                  phase_q, phase_d;
	logic signed [ppr_pkg::NUM_W-1:0] cur_num_q, cur_num_d;
	logic signed [ppr_pkg::NUM_W-1:0] cur_val_q, cur_val_d;
	logic signed [ppr_pkg::NUM_W-1:0] highest_q, highest_d;
	logic [ppr_pkg::CNT_W-1:0]        promise_q, promise_d;
	logic [ppr_pkg::CNT_W-1:0]        accept_q, accept_d;
	logic [ppr_pkg::CNT_W-1:0]        answered_q, answered_d;

	logic [ppr_pkg::CNT_W-1:0] count;
	logic [ppr_pkg::CNT_W-1:0] quorum;
	logic [ppr_pkg::CNT_W-1:0] answered_inc;
	logic [ppr_pkg::CNT_W-1:0] promise_n;
	logic [ppr_pkg::CNT_W-1:0] accept_n;
	logic                      take;
	flags_t                    fl;

	// Clamp the acceptor count and derive the quorum
	assign count  = (acceptor_count > MAX_CNT) ? MAX_CNT : acceptor_count;
	assign quorum = {1'b0, count[ppr_pkg::CNT_W-1:1]} + 1'b1;

	// Decide what this item does
	always_comb begin
		fl           = '0;
		answered_inc = ppr_pkg::sat_inc(answered_q);
		take         = item.proposal_number <= cur_num_q;
		promise_n    = take ? ppr_pkg::sat_inc(promise_q) : promise_q;
		accept_n     = ppr_pkg::sat_inc(accept_q);
		case (ppr_pkg::action_t'(item.action))
			ppr_pkg::A_START: begin
				fl.is_start = 1'b1;
			end
			ppr_pkg::A_PREP: begin
				if (phase_q == ppr_pkg::PH_PREP) begin
					fl.busy_reply = item.busy_req;
					fl.prep_done  = !item.busy_req;
				end
			end
			ppr_pkg::A_ACC: begin
				if (phase_q == ppr_pkg::PH_ACC) begin
					fl.busy_reply = item.busy_req;
					fl.acc_done   = !item.busy_req;
				end
			end
			default: begin
			end
		endcase
		fl.adopt    = fl.prep_done && take && (item.proposal_number > highest_q);
		fl.reach_p  = fl.prep_done && (promise_n >= quorum);
		fl.fail_p   = fl.prep_done && !fl.reach_p && (answered_inc >= count);
		fl.too_high = fl.acc_done && !take;
		fl.chosen   = fl.acc_done && take && (accept_n >= quorum);
		fl.fail_a   = fl.acc_done && (!take || (!fl.chosen && (answered_inc >= count)));
	end

	// Next state
	always_comb begin
		phase_d    = phase_q;
		cur_num_d  = cur_num_q;
		cur_val_d  = cur_val_q;
		highest_d  = highest_q;
		promise_d  = promise_q;
		accept_d   = accept_q;
		answered_d = answered_q;
		if (fl.is_start) begin
			phase_d    = ppr_pkg::PH_PREP;
			cur_num_d  = item.proposal_number;
			cur_val_d  = item.proposal_number;
			highest_d  = '0;
			promise_d  = '0;
			accept_d   = '0;
			answered_d = '0;
		end else if (fl.prep_done) begin
			promise_d  = promise_n;
			answered_d = answered_inc;
			if (fl.adopt) begin
				highest_d = item.proposal_number;
				cur_val_d = item.reply_value;
			end
			if (fl.reach_p) begin
				phase_d    = ppr_pkg::PH_ACC;
				answered_d = '0;
				accept_d   = '0;
			end else if (fl.fail_p) begin
				phase_d = ppr_pkg::PH_IDLE;
			end
		end else if (fl.acc_done) begin
			answered_d = answered_inc;
			if (!fl.too_high) begin
				accept_d = accept_n;
			end
			if (fl.chosen || fl.fail_a) begin
				phase_d = ppr_pkg::PH_IDLE;
			end
		end
	end

	// Result of the item
	always_comb begin
		res.kind = ppr_pkg::K_NONE;
		if (fl.busy_reply) begin
			res.kind = ppr_pkg::K_RESEND;
		end else if (fl.reach_p) begin
			res.kind = ppr_pkg::K_ACCEPT_REQ;
		end else if (fl.chosen) begin
			res.kind = ppr_pkg::K_CHOSEN;
		end else if (fl.fail_p || fl.fail_a) begin
			res.kind = ppr_pkg::K_FAILED;
		end
		res.target_id    = fl.busy_reply ? item.acceptor_id : '0;
		res.round_number = cur_num_d;
		res.round_value  = cur_val_d;
	end

	// Commit state when the item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= ppr_pkg::PH_IDLE;
			cur_num_q  <= '0;
			cur_val_q  <= '0;
			highest_q  <= '0;
			promise_q  <= '0;
			accept_q   <= '0;
			answered_q <= '0;
		end else if (fire) begin
			phase_q    <= phase_d;
			cur_num_q  <= cur_num_d;
			cur_val_q  <= cur_val_d;
			highest_q  <= highest_d;
			promise_q  <= promise_d;
			accept_q   <= accept_d;
			answered_q <= answered_d;
		end
	end

`ifndef SYNTHESIS
	// A start opens a clean preparing round
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (item.action == ppr_pkg::A_START) |=>
		(phase_q == ppr_pkg::PH_PREP) && (promise_q == '0) && (answered_q == '0))
		else $error("start did not open a clean round");

	// An accept request only leaves the preparing phase, into accepting
	a_accept_req_phase: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (res.kind == ppr_pkg::K_ACCEPT_REQ) |->
		(phase_q == ppr_pkg::PH_PREP) ##1 (phase_q == ppr_pkg::PH_ACC))
		else $error("accept request outside preparing phase");

	// Chosen or failed always ends the round
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && ((res.kind == ppr_pkg::K_CHOSEN) || (res.kind == ppr_pkg::K_FAILED)) |=>
		(phase_q == ppr_pkg::PH_IDLE))
		else $error("round end did not return to idle");

	// A reply while idle leaves the round untouched
	a_idle_ignore: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (phase_q == ppr_pkg::PH_IDLE) && (item.action != ppr_pkg::A_START) |=>
		$stable(cur_num_q) && $stable(cur_val_q) && $stable(promise_q))
		else $error("idle reply changed round state");
`endif

endmodule

[hdl/paxos_proposer_round.sv]
// Top level of the Paxos proposer round: APB register, item and result
// registers around ppr_round. Depends on ppr_pkg, ppr_if and ppr_round.

// Takes one item per cycle unless a full result register is stalled by the
// output side, and gives exactly one result item for each: the item is
// registered, the round decision (reply counting, quorum compare, signed
// number compares) is a single pass of logic, and the result is
// registered. A waiting result does not block the next item from entering
// the input register. The acceptor count register sits at byte address 0
// and should be written only while no item is in flight.
module paxos_proposer_round #(
	parameter int MAX_ACCEPTORS = ppr_pkg::MAX_ACCEPTORS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	ppr_item_if.sink    req,
	ppr_result_if.source rsp
);

	logic [ppr_pkg::CNT_W-1:0] acceptor_count_q;
	logic                      s1_valid_q;
	ppr_pkg::item_t            item_s1;
	logic                      out_valid_q;
	ppr_pkg::result_t          result_q;
	ppr_pkg::result_t          res;
	logic                      adv;
	logic                      reg_hit;

	// Register decode: word index in paddr[2]
	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == 1'(ppr_pkg::REG_ACCEPTOR_COUNT));
	assign prdata  = reg_hit ? {28'd0, acceptor_count_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acceptor_count_q <= ppr_pkg::CNT_W'(ppr_pkg::ACC_COUNT_RESET);
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			acceptor_count_q <= pwdata[ppr_pkg::CNT_W-1:0];
		end
	end

	// Advance the item when the result register is free or being drained
	assign adv       = s1_valid_q && (!out_valid_q || rsp.ready);
	assign req.ready = !s1_valid_q || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req.valid && req.ready) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.action          <= req.action;
			item_s1.acceptor_id     <= req.acceptor_id;
			item_s1.busy_req        <= req.busy_req;
			item_s1.proposal_number <= req.proposal_number;
			item_s1.reply_value     <= req.reply_value;
		end
	end

	ppr_round #(
		.MAX_ACCEPTORS(MAX_ACCEPTORS)
	) u_round (
		.clk            (clk),
		.arst_n         (arst_n),
		.acceptor_count (acceptor_count_q),
		.fire           (adv),
		.item           (item_s1),
		.res            (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= res;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.kind         = result_q.kind;
	assign rsp.target_id    = result_q.target_id;
	assign rsp.round_number = result_q.round_number;
	assign rsp.round_value  = result_q.round_value;

endmodule

[bench/ppr_check_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard for the Paxos proposer round: predicts one result per item.
// Depends on ppr_pkg for item, result, phase and kind types.

package ppr_check_pkg;
	import ppr_pkg::*;

	class round_scoreboard;
		logic [3:0]         acc_count;
		phase_t             ph;
		logic signed [31:0] cur_num;
		logic signed [31:0] cur_val;
		logic signed [31:0] best_num;
		logic [3:0]         promises;
		logic [3:0]         accepts;
		logic [3:0]         answers;
		result_t            outcome_q[$];
		int                 errors;
		int                 items_seen;
		int                 results_seen;

		function new();
			acc_count    = 4'(ACC_COUNT_RESET);
			ph           = PH_IDLE;
			cur_num      = '0;
			cur_val      = '0;
			best_num     = '0;
			promises     = '0;
			accepts      = '0;
			answers      = '0;
			errors       = 0;
			items_seen   = 0;
			results_seen = 0;
		endfunction

		function void set_count(logic [3:0] c);
			acc_count = c;
		endfunction

		function int pending();
			return outcome_q.size();
		endfunction

		// Saturate a reply counter at its top value
		function logic [3:0] bump(logic [3:0] c);
			return (c == 4'hF) ? c : c + 4'd1;
		endfunction

		// Advance the round state for one accepted item and queue its result
		function void note_item(item_t it);
			logic [3:0]         cnt;
			logic [3:0]         quorum;
			logic signed [31:0] num;
			logic signed [31:0] val;
			kind_t              k;
			logic [3:0]         tgt;
			result_t            r;
			cnt    = (acc_count > 4'(MAX_ACCEPTORS_DEF)) ? 4'(MAX_ACCEPTORS_DEF) : acc_count;
			quorum = cnt / 4'd2 + 4'd1;
			num    = it.proposal_number;
			val    = it.reply_value;
			k      = K_NONE;
			tgt    = '0;
			items_seen++;
			if (it.action == A_START) begin
				cur_num  = num;
				cur_val  = num;
				best_num = '0;
				promises = '0;
				accepts  = '0;
				answers  = '0;
				ph       = PH_PREP;
			end else if (it.action == A_PREP && ph == PH_PREP) begin
				if (it.busy_req) begin
					k   = K_RESEND;
					tgt = it.acceptor_id;
				end else begin
					answers = bump(answers);
					if (num <= cur_num) begin
						if (num > best_num) begin
							best_num = num;
							cur_val  = val;
						end
						promises = bump(promises);
					end
					if (promises >= quorum) begin
						k       = K_ACCEPT_REQ;
						ph      = PH_ACC;
						answers = '0;
						accepts = '0;
					end else if (answers >= cnt) begin
						k  = K_FAILED;
						ph = PH_IDLE;
					end
				end
			end else if (it.action == A_ACC && ph == PH_ACC) begin
				if (it.busy_req) begin
					k   = K_RESEND;
					tgt = it.acceptor_id;
				end else begin
					answers = bump(answers);
					if (num > cur_num) begin
						k  = K_FAILED;
						ph = PH_IDLE;
					end else begin
						accepts = bump(accepts);
						if (accepts >= quorum) begin
							k  = K_CHOSEN;
							ph = PH_IDLE;
						end else if (answers >= cnt) begin
							k  = K_FAILED;
							ph = PH_IDLE;
						end
					end
				end
			end
			r.kind         = k;
			r.target_id    = tgt;
			r.round_number = cur_num;
			r.round_value  = cur_val;
			// Append at the tail of the expectation list
			outcome_q.insert(outcome_q.size(), r);
		endfunction

		// Compare one result item against the oldest expectation
		function void check_result(result_t got);
			result_t want;
			results_seen++;
			if (outcome_q.size() == 0) begin
				$error("result item with no expected item pending");
				errors++;
				return;
			end
			// Take the oldest expectation off the head
			want = outcome_q[0];
			outcome_q.delete(0);
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, got.kind);
				errors++;
			end
			if (got.target_id !== want.target_id) begin
				$error("target_id: expected %0d, got %0d", want.target_id, got.target_id);
				errors++;
			end
			if (got.round_number !== want.round_number) begin
				$error("round_number: expected %0d, got %0d", want.round_number,
					got.round_number);
				errors++;
			end
			if (got.round_value !== want.round_value) begin
				$error("round_value: expected %0d, got %0d", want.round_value,
					got.round_value);
				errors++;
			end
		endfunction
	endclass

endpackage

[bench/tb_paxos_proposer_round.sv]
`timescale 1ns / 1ps
// Top of the proposer round testbench: clock, reset, APB and item drivers.
// Depends on ppr_pkg, ppr_if, ppr_check_pkg and the paxos_proposer_round RTL.

module tb_paxos_proposer_round;
	import ppr_pkg::*;
	import ppr_check_pkg::*;

	localparam logic [1:0]         ACT_UNUSED  = 2'd3;
	localparam logic signed [31:0] NUM_MAX     = 32'sh7fffffff;
	localparam int                 LATENCY     = 2;
	localparam int                 HOLD_CYCLES = 40;
	localparam int                 PHASE_ITEMS = 80;
	localparam int                 LIMIT       = 200000;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	ppr_item_if   item_ch();
	ppr_result_if result_ch();

	round_scoreboard sb;
	int              cycles;
	int              settings_done;
	bit              quiet;
	bit              hold_off;

	paxos_proposer_round dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (item_ch),
		.rsp     (result_ch)
	);

	// Free-running clock, 10 ns period
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Count cycles for the run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	initial begin
		while (cycles < LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	// Check every result item taken from the block
	always @(posedge clk) begin
		result_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.kind         = kind_t'(result_ch.kind);
			got.target_id    = result_ch.target_id;
			got.round_number = result_ch.round_number;
			got.round_value  = result_ch.round_value;
			sb.check_result(got);
		end
	end

	// Result side: random stall bursts, one long hold-off on request
	initial begin
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_off) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end else if (!quiet && $urandom_range(7, 0) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(5, 1)) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Offer one item and hold it until the block takes it
	task automatic send_item(input item_t it);
		item_ch.valid           <= 1'b1;
		item_ch.action          <= it.action;
		item_ch.acceptor_id     <= it.acceptor_id;
		item_ch.busy_req        <= it.busy_req;
		item_ch.proposal_number <= it.proposal_number;
		item_ch.reply_value     <= it.reply_value;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_item(it);
	endtask

	// Build an item, maybe idle first, then send it
	task automatic offer(input logic [1:0] act, input logic [3:0] id, input logic busy,
		input logic signed [31:0] num, input logic signed [31:0] val);
		item_t it;
		it.action          = act;
		it.acceptor_id     = id;
		it.busy_req        = busy;
		it.proposal_number = num;
		it.reply_value     = val;
		if (!quiet && $urandom_range(3, 0) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(5, 1)) @(posedge clk);
		end
		send_item(it);
	endtask

	// Drop valid and wait until every expected result has come back
	task automatic drain();
		item_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle
	task automatic write_acceptor_count(input logic [3:0] c);
		drain();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(REG_ACCEPTOR_COUNT * 4);
		pwdata  <= 32'(c);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_count(c);
		settings_done++;
	endtask

	// Proposal numbers within the field's range, with -1, the largest number and small values favored
	function automatic logic signed [31:0] rand_num();
		case ($urandom_range(7, 0))
			0: return -32'sd1;
			1: return NUM_MAX;
			2, 3: return 32'($urandom_range(20, 0));
			default: return $signed($urandom & 32'h7fffffff);
		endcase
	endfunction

	function automatic logic signed [31:0] num_at_most(input logic signed [31:0] n);
		if (n < 0)
			return -32'sd1;
		case ($urandom_range(3, 0))
			0: return -32'sd1;
			1: return n;
			default: return $signed($urandom_range(32'(n), 0));
		endcase
	endfunction

	function automatic logic signed [31:0] num_above(input logic signed [31:0] n);
		return $signed($urandom_range(32'h7fffffff, 32'(n + 1)));
	endfunction

	function automatic logic [3:0] rand_id();
		return 4'($urandom_range(14, 0));
	endfunction

	// Random item of any action, including the unused one
	task automatic noise_item();
		offer(2'($urandom_range(3, 0)), rand_id(), 1'($urandom), rand_num(), rand_num());
	endtask

	// One well-formed round with random replies; sometimes abandoned early
	task automatic gen_round(inout int sent);
		logic signed [31:0] n;
		logic signed [31:0] num;
		int                 tries;
		n = rand_num();
		offer(A_START, rand_id(), 1'($urandom), n, rand_num());
		sent++;
		tries = 0;
		while (sb.ph == PH_PREP && tries < 20) begin
			if (n == NUM_MAX || $urandom_range(9, 0) < 7)
				num = num_at_most(n);
			else
				num = num_above(n);
			offer(A_PREP, rand_id(), $urandom_range(7, 0) == 0, num, rand_num());
			sent++;
			tries++;
			if ($urandom_range(29, 0) == 0)
				return;
		end
		tries = 0;
		while (sb.ph == PH_ACC && tries < 20) begin
			if (n == NUM_MAX || $urandom_range(9, 0) != 0)
				num = num_at_most(n);
			else
				num = num_above(n);
			offer(A_ACC, rand_id(), $urandom_range(7, 0) == 0, num, rand_num());
			sent++;
			tries++;
		end
	endtask

	// Mostly rounds, some noise, until the phase has its share of items
	task automatic random_phase(input logic [3:0] c, input bit squeeze);
		int sent;
		sent = 0;
		write_acceptor_count(c);
		while (sent < PHASE_ITEMS) begin
			if (squeeze && sent >= PHASE_ITEMS / 2) begin
				// Hold the result side and offer twenty noise items so that the input stalls
				drain();
				squeeze  = 1'b0;
				quiet    = 1'b1;
				hold_off = 1'b1;
				repeat (20) begin
					noise_item();
					sent++;
				end
				quiet = 1'b0;
			end
			if ($urandom_range(4, 0) == 0) begin
				noise_item();
				sent++;
			end else begin
				gen_round(sent);
			end
		end
	endtask

	initial begin
		sb            = new();
		cycles        = 0;
		settings_done = 0;
		quiet         = 1'b0;
		hold_off      = 1'b0;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		item_ch.valid           = 1'b0;
		item_ch.action          = '0;
		item_ch.acceptor_id     = '0;
		item_ch.busy_req        = 1'b0;
		item_ch.proposal_number = '0;
		item_ch.reply_value     = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset count of five: busy, no prior accept, adopt, skip, equal
		offer(A_START, 4'd0, 1'b0, 32'sd100, 32'sd0);
		offer(A_PREP, 4'd14, 1'b1, 32'sd3, 32'sd3);
		offer(A_PREP, 4'd0, 1'b0, -32'sd1, -32'sd1);
		offer(A_PREP, 4'd1, 1'b0, 32'sd50, 32'sd7);
		offer(A_PREP, 4'd2, 1'b0, 32'sd200, 32'sd8);
		offer(A_PREP, 4'd3, 1'b0, 32'sd100, 32'sd9);
		// Higher minimum proposal fails the accept phase
		offer(A_ACC, 4'd4, 1'b0, 32'sd101, 32'sd0);
		// Wrong phase and unused action are ignored
		offer(A_ACC, 4'd5, 1'b0, 32'sd0, 32'sd0);
		offer(ACT_UNUSED, 4'd15, 1'b1, -32'sd1, -32'sd1);
		// Largest number, repeated acceptor, busy accept, then chosen
		offer(A_START, 4'd0, 1'b0, NUM_MAX, NUM_MAX);
		offer(A_PREP, 4'd6, 1'b0, NUM_MAX, NUM_MAX);
		offer(A_PREP, 4'd6, 1'b0, -32'sd1, 32'sd0);
		offer(A_PREP, 4'd7, 1'b0, 32'sd12, 32'sd12);
		offer(A_ACC, 4'd8, 1'b1, 32'sd0, 32'sd0);
		offer(A_ACC, 4'd9, 1'b0, NUM_MAX, 32'sd0);
		offer(A_ACC, 4'd10, 1'b0, -32'sd1, 32'sd0);
		offer(A_ACC, 4'd11, 1'b0, 32'sd0, 32'sd0);
		// Every acceptor answers with a higher proposal: round fails
		offer(A_START, 4'd0, 1'b0, -32'sd1, 32'sd0);
		repeat (5) offer(A_PREP, 4'd12, 1'b0, 32'sd20, 32'sd5);
		// Restart in the middle of a round
		offer(A_START, 4'd0, 1'b0, 32'sd0, 32'sd0);
		offer(A_PREP, 4'd13, 1'b0, 32'sd0, 32'sd0);
		offer(A_START, 4'd0, 1'b0, 32'sd1, 32'sd0);

		// Random phases over several acceptor counts, extremes included
		random_phase(4'd15, 1'b0);
		random_phase(4'd1, 1'b1);
		random_phase(4'd0, 1'b0);
		random_phase(4'($urandom_range(14, 2)), 1'b0);
		random_phase(4'd3, 1'b0);
		quiet = 1'b1;
		random_phase(4'd5, 1'b0);

		drain();
		repeat (LATENCY + 4) @(posedge clk);
		$display("summary: %0d items over %0d acceptor-count settings, %0d results checked",
			sb.items_seen, settings_done, sb.results_seen);
		$display("summary: %0d mismatches, %0d results still outstanding", sb.errors,
			sb.pending());
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
